[src/sem_pkg.sv]
package sem_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int REG_WIDTH_W  = 11;
  localparam int REG_HEIGHT_W = 13;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int QUEUE_DEPTH    = 4;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_pixel;
    logic             frame_end;
  } out_item_t;

  // command flags handed from the front to the back
  typedef struct packed {
    logic is_drain;   // read the line store only, no write
    logic emit;       // this command produces a result
    logic sobel;      // result is the gradient magnitude, else the direct value
    logic sel_lower;  // drain reads the lower line, else the upper line
    logic frame_end;  // final result of the frame
  } cmd_ctrl_t;

  // last valid index for a size register: zero reads as one, clamp to limit
  function automatic int unsigned clamp_last(input int unsigned value,
                                             input int unsigned limit);
    int unsigned r;
    if (value == 0) begin
      r = 0;
    end else if (value > limit) begin
      r = limit - 1;
    end else begin
      r = value - 1;
    end
    return r;
  endfunction

endpackage

[src/sem_queue.sv]
module sem_queue import sem_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[src/sem_front.sv]
module sem_front import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_ctrl_t              q_ctrl,
  output logic [COL_W-1:0]       q_col,
  output logic [PIX_W-1:0]       q_px
);

  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic             frame_loaded, frame_loaded_next;

  logic accept;
  logic ready;
  logic border;
  logic last;
  logic emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_px     = in_item.pixel_in;

  // an output trails the input by one row and one pixel
  assign ready  = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign border = (out_row == '0) || (out_row == last_row) ||
                  (out_col == '0) || (out_col == last_col);
  assign last   = (out_row == last_row) && (out_col == last_col);

  always_comb begin
    in_col_next       = in_col;
    in_row_next       = in_row;
    out_col_next      = out_col;
    out_row_next      = out_row;
    frame_loaded_next = frame_loaded;
    q_push            = 1'b0;
    q_ctrl            = '0;
    q_col             = in_col;
    emit              = 1'b0;

    if (accept) begin
      if (in_item.opcode == OP_PIXEL && !frame_loaded) begin
        q_push          = 1'b1;
        emit            = ready;
        q_ctrl.emit     = ready;
        q_ctrl.sobel    = ready && (in_col != '0) && !border;
        q_ctrl.frame_end = ready && last;
        if (in_col == last_col) begin
          in_col_next = '0;
          if (in_row == last_row) begin
            frame_loaded_next = 1'b1;
          end else begin
            in_row_next = in_row + ROW_W'(1);
          end
        end else begin
          in_col_next = in_col + COL_W'(1);
        end
      end else if (in_item.opcode == OP_DRAIN && frame_loaded) begin
        q_push           = 1'b1;
        emit             = 1'b1;
        q_col            = out_col;
        q_ctrl.is_drain  = 1'b1;
        q_ctrl.emit      = 1'b1;
        q_ctrl.sel_lower = (out_row == last_row);
        q_ctrl.frame_end = last;
      end
    end

    if (emit) begin
      if (last) begin
        in_col_next       = '0;
        in_row_next       = '0;
        out_col_next      = '0;
        out_row_next      = '0;
        frame_loaded_next = 1'b0;
      end else if (out_col == last_col) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_W'(1);
      end else begin
        out_col_next = out_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col     <= COL_W'(clamp_last(WIDTH_RESET, MAX_WIDTH));
      last_row     <= ROW_W'(clamp_last(HEIGHT_RESET, MAX_HEIGHT));
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      frame_loaded <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          last_col <= COL_W'(clamp_last(32'(cfg_data[REG_WIDTH_W-1:0]), MAX_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          last_row <= ROW_W'(clamp_last(32'(cfg_data[REG_HEIGHT_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      frame_loaded <= 1'b0;
    end else begin
      in_col       <= in_col_next;
      in_row       <= in_row_next;
      out_col      <= out_col_next;
      out_row      <= out_row_next;
      frame_loaded <= frame_loaded_next;
    end
  end

`ifndef SYNTHESIS
  a_loaded_col_zero: assert property (@(posedge clk) disable iff (rst)
    frame_loaded |-> (in_col == '0))
    else $error("input column not parked while frame is loaded");

  a_cols_in_range: assert property (@(posedge clk) disable iff (rst)
    (in_col <= last_col) && (out_col <= last_col))
    else $error("column counter beyond row width");

  a_rows_in_range: assert property (@(posedge clk) disable iff (rst)
    (in_row <= last_row) && (out_row <= last_row))
    else $error("row counter beyond frame height");
`endif

endmodule

[src/sem_back.sv]
module sem_back import sem_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  cmd_ctrl_t        q_ctrl,
  input  logic [COL_W-1:0] q_col,
  input  logic [PIX_W-1:0] q_px,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int LINE_W = 2 * PIX_W;
  localparam int G_W    = PIX_W + 3;

  // line store: upper line in the high byte, lower line in the low byte
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rdata;
  logic [LINE_W-1:0] wdata;
  logic              wr_en;
  logic              adv;

  logic             b1_valid;
  cmd_ctrl_t        b1_ctrl;
  logic [COL_W-1:0] b1_col;
  logic [PIX_W-1:0] b1_px;

  logic [PIX_W-1:0] nb [3][3];
  logic [PIX_W-1:0] direct_val;

  logic             b2_valid;
  cmd_ctrl_t        b2_ctrl;
  logic [PIX_W-1:0] b2_direct;

  logic                  b3_valid;
  cmd_ctrl_t             b3_ctrl;
  logic [PIX_W-1:0]      b3_direct;
  logic signed [G_W-1:0] b3_gx;
  logic signed [G_W-1:0] b3_gy;

  logic signed [G_W-1:0] gx;
  logic signed [G_W-1:0] gy;
  logic signed [G_W-1:0] neg_gx;
  logic signed [G_W-1:0] neg_gy;
  logic [G_W-2:0]        abs_gx;
  logic [G_W-2:0]        abs_gy;
  logic [G_W-1:0]        mag_sum;
  logic [G_W-2:0]        mag_half;
  logic [PIX_W-1:0]      mag_sat;

  // whole back pipe moves when the output register is free or being taken
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  assign wr_en = adv && b1_valid && !b1_ctrl.is_drain;
  assign wdata = {rdata[PIX_W-1:0], b1_px};

  // write-first bypass covers back-to-back access to one column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[b1_col] <= wdata;
    end
    if (q_pop) begin
      rdata <= (wr_en && (b1_col == q_col)) ? wdata : line_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_ctrl <= q_ctrl;
      b1_col  <= q_col;
      b1_px   <= q_px;
    end
  end

  // 3x3 window, rows top to bottom, column 2 newest
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        nb[r][0] <= nb[r][1];
        nb[r][1] <= nb[r][2];
      end
      nb[0][2] <= rdata[LINE_W-1:PIX_W];
      nb[1][2] <= rdata[PIX_W-1:0];
      nb[2][2] <= b1_px;
    end
  end

  // border value of a pixel step is the center after the shift (also the
  // end of the row above when the input sits at column zero)
  always_comb begin
    if (b1_ctrl.is_drain) begin
      direct_val = b1_ctrl.sel_lower ? rdata[PIX_W-1:0] : rdata[LINE_W-1:PIX_W];
    end else begin
      direct_val = nb[1][2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_ctrl   <= b1_ctrl;
      b2_direct <= direct_val;
    end
  end

  always_comb begin
    logic signed [G_W-1:0] p [3][3];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = $signed({3'b000, nb[i][j]});
      end
    end
    gx = (p[0][0] - p[0][2]) + ((p[1][0] - p[1][2]) <<< 1) + (p[2][0] - p[2][2]);
    gy = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_ctrl   <= b2_ctrl;
      b3_direct <= b2_direct;
      b3_gx     <= gx;
      b3_gy     <= gy;
    end
  end

  assign neg_gx   = -b3_gx;
  assign neg_gy   = -b3_gy;
  assign abs_gx   = b3_gx[G_W-1] ? neg_gx[G_W-2:0] : b3_gx[G_W-2:0];
  assign abs_gy   = b3_gy[G_W-1] ? neg_gy[G_W-2:0] : b3_gy[G_W-2:0];
  assign mag_sum  = {1'b0, abs_gx} + {1'b0, abs_gy};
  assign mag_half = mag_sum[G_W-1:1];
  assign mag_sat  = (mag_half > (G_W-1)'(255)) ? {PIX_W{1'b1}} : mag_half[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (adv && b3_valid && b3_ctrl.emit) begin
      out_item.edge_pixel <= b3_ctrl.sobel ? mag_sat : b3_direct;
      out_item.frame_end  <= b3_ctrl.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= !q_empty;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid && b3_ctrl.emit;
    end
  end

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b3_valid && b3_ctrl.emit))
    else $error("result shown without an emitting command");
`endif

endmodule

[src/sobel_edge_magnitude_stream.sv]
// Streaming 3x3 Sobel edge detector. Grayscale pixels enter in raster order
// and the edge image leaves in raster order, one row plus one pixel behind
// the input; interior results are min(255, (|Gx|+|Gy|) >> 1), first/last
// rows and columns pass the source pixel through. Once the last pixel of a
// frame is in, send drain items: each one returns the next pending result,
// and the result with frame_end set closes the frame. Pixels sent between
// the end of the frame and its final result are dropped; a drain sent while
// no frame is complete is ignored. Writing image_width or image_height
// (only while idle) restarts the frame. While the output is not stalled
// the block sustains one item per clock: the single line store takes one
// read and one write per clock, so nothing in the pixel path iterates.
// Queued commands move through stages b1, b2 and b3 toward the output
// register, and the whole back pipe holds for each stalled cycle; input
// stall rises only when the 4-entry command queue fills, which happens
// only while the output is stalled. No clearing pass is needed after reset.
module sobel_edge_magnitude_stream import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CTRL_W = $bits(cmd_ctrl_t);
  localparam int CMD_W  = CTRL_W + COL_W + PIX_W;

  // front -> queue
  logic             f_push;
  cmd_ctrl_t        f_ctrl;
  logic [COL_W-1:0] f_col;
  logic [PIX_W-1:0] f_px;

  // queue -> back
  logic [CMD_W-1:0] q_head;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  cmd_ctrl_t        h_ctrl;
  logic [COL_W-1:0] h_col;
  logic [PIX_W-1:0] h_px;

  // Front: owns the frame counters, drops late pixels and idle drains, and
  // decides per transfer whether a result comes out and of which kind.
  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_ctrl    (f_ctrl),
    .q_col     (f_col),
    .q_px      (f_px)
  );

  // Short command queue decouples input stalls from output stalls.
  sem_queue #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctrl, f_col, f_px}),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign h_ctrl = cmd_ctrl_t'(q_head[CMD_W-1 -: CTRL_W]);
  assign h_col  = q_head[PIX_W +: COL_W];
  assign h_px   = q_head[PIX_W-1:0];

  // Back: line store, 3x3 window, gradient pipe and output register.
  sem_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_ctrl    (h_ctrl),
    .q_col     (h_col),
    .q_px      (h_px),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
